// ===== hw/rtl/twcs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twcs_pkg
// Shared types and constants for the textured wall column span core.
// ---------------------------------------------------------------------------
package twcs_pkg;

  localparam int SCREEN_H  = 64;
  localparam int TEX_SIZE  = 64;
  localparam int HALF_H    = SCREEN_H / 2;
  localparam int ROW_W     = $clog2(SCREEN_H + 1);
  localparam int TEX_W     = $clog2(TEX_SIZE);
  localparam int LH_W      = 16;
  localparam int NUM_MAX   = (SCREEN_H > TEX_SIZE) ? SCREEN_H : TEX_SIZE;
  localparam int DVD_W     = $clog2(NUM_MAX) + 17;
  localparam int DVS_W     = 24;
  localparam int QDEPTH    = 2;

  typedef struct packed {
    logic [9:0]         column;
    logic               hit_side;
    logic [23:0]        wall_distance;
    logic [23:0]        player_x;
    logic [23:0]        player_y;
    logic signed [19:0] ray_dx;
    logic signed [19:0] ray_dy;
  } in_item_t;

  typedef struct packed {
    logic [9:0] out_column;
    logic [5:0] row;
    logic [5:0] texel_u;
    logic [5:0] texel_v;
    logic [1:0] face;
    logic       write_enable;
    logic       last_pixel;
  } out_item_t;

  // One column's drawing job, handed from the front to the back.
  typedef struct packed {
    logic [9:0]       column;
    logic [TEX_W-1:0] texel_u;
    logic [1:0]       face;
    logic             face_valid;
    logic [ROW_W-1:0] start_row;
    logic [ROW_W-1:0] stop_row;
    logic [31:0]      tex_step;
    logic [31:0]      tex_position;
  } span_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV_LH,
    F_DIV_STEP,
    F_POS,
    F_PUSH
  } front_state_t;

endpackage

// ===== hw/rtl/textured_wall_column_span_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// textured_wall_column_span_core
// Turns one ray hit per screen column into a run of textured wall pixels.
// ---------------------------------------------------------------------------
// Each input word is the ray hit of one screen column. The core divides the
// screen height by the perpendicular distance to get the slice height (a zero
// distance or an oversized quotient saturates to 65535), clips the slice to
// the screen, picks one of four face textures from the hit side and the sign
// of the ray direction, and finds the texture column from the fraction of the
// wall hit, mirrored on faces 0 and 3. It then sends one output word per drawn
// row, top to bottom, with the texture row stepped in Q16.16, and marks the
// final row with last_pixel. A slice of height 0 or 1 draws nothing and gives
// no output word. Only one column is in the front end at a time: it runs the
// one-bit-per-cycle divider twice (slice height, then texture step), then a
// multiply and a queue push, and takes no new word until the push is done.
// The back end picks up a job from the queue and then sends one row per cycle
// while the output is not stalled. A two-entry job queue between the two lets
// the next column's arithmetic run while the current one is drawn.
// ---------------------------------------------------------------------------
module textured_wall_column_span_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  twcs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output twcs_pkg::out_item_t  out_data
);
  import twcs_pkg::*;

  queue_stat_t q_stat;
  span_desc_t  push_desc;
  span_desc_t  pop_desc;
  logic        q_push;
  logic        q_pop;

  // Front end: acceptance, division, span and face classification.
  twcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  // Job queue: decouples the arithmetic from the pixel stream.
  twcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .pop_desc  (pop_desc),
    .stat      (q_stat)
  );

  // Back end: row walker with a registered output word.
  twcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_desc    (pop_desc),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // The front end must never write into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_stat.full))
    else $error("span queue overflow");

  // The back end must never take a job from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_stat.empty))
    else $error("span queue underflow");

  // Every queued job has at least one row to draw.
  assert property (@(posedge clk) disable iff (!rst_n)
                   q_push |-> (push_desc.start_row < push_desc.stop_row))
    else $error("empty span queued");
`endif

endmodule

// ===== hw/rtl/twcs_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twcs_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module twcs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [twcs_pkg::DVD_W-1:0]  dividend,
  input  logic [twcs_pkg::DVS_W-1:0]  divisor,
  output logic                        done,
  output logic [twcs_pkg::DVD_W-1:0]  quotient
);
  import twcs_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] work_r;

  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W:0]   diff;

  always_comb begin
    trial = {rem_r, work_r[DVD_W-1]};
    ge    = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      dvs_r  <= divisor;
      work_r <= dividend;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      work_r <= {work_r[DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = work_r;

endmodule

// ===== hw/rtl/twcs_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twcs_front
// Accepts ray hits, works out span, texture step, start position and face.
// ---------------------------------------------------------------------------
module twcs_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  twcs_pkg::in_item_t     in_data,
  input  twcs_pkg::queue_stat_t  q_stat,
  output logic                   q_push,
  output twcs_pkg::span_desc_t   q_desc
);
  import twcs_pkg::*;

  front_state_t     state_r, state_nxt;
  in_item_t         item_r;
  logic [31:0]      prod_r;
  logic [LH_W-1:0]  lh_r;
  logic [ROW_W-1:0] start_r;
  logic [ROW_W-1:0] stop_r;
  logic [31:0]      step_r;
  logic [31:0]      pos_r;

  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;

  logic [LH_W-1:0]  lh_sat;
  logic [LH_W-2:0]  half;
  logic             clip;
  logic [ROW_W-1:0] start_c;
  logic [ROW_W-1:0] stop_c;
  logic             span_empty;
  logic [LH_W-2:0]  half_r;
  logic [LH_W-2:0]  offset;
  logic [LH_W+30:0] pos_prod;
  logic signed [19:0] dir;
  logic signed [44:0] hit_prod;
  logic [15:0]      frac;
  logic [TEX_W-1:0] u_raw;
  logic             mirror;
  logic             dx_pos, dx_neg, dy_pos, dy_neg;

  twcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Height saturation and span clipping.
  always_comb begin
    lh_sat     = (|div_quot[DVD_W-1:LH_W]) ? {LH_W{1'b1}} : div_quot[LH_W-1:0];
    half       = lh_sat[LH_W-1:1];
    clip       = half >= (LH_W-1)'(HALF_H);
    start_c    = clip ? '0 : ROW_W'((LH_W-1)'(HALF_H) - half);
    stop_c     = clip ? ROW_W'(SCREEN_H) : ROW_W'(half + (LH_W-1)'(HALF_H));
    span_empty = (half == '0);
  end

  // Texture row offset of the first drawn row.
  always_comb begin
    half_r   = lh_r[LH_W-1:1];
    offset   = (half_r > (LH_W-1)'(HALF_H)) ? half_r - (LH_W-1)'(HALF_H) : '0;
    pos_prod = offset * step_r;
  end

  // Wall hit position along the face.
  always_comb begin
    dir      = item_r.hit_side ? item_r.ray_dx : item_r.ray_dy;
    hit_prod = $signed({1'b0, item_r.wall_distance}) * dir;
    dx_pos   = !item_r.ray_dx[19] && (|item_r.ray_dx);
    dx_neg   = item_r.ray_dx[19];
    dy_pos   = !item_r.ray_dy[19] && (|item_r.ray_dy);
    dy_neg   = item_r.ray_dy[19];
    frac     = (item_r.hit_side ? item_r.player_x[15:0] : item_r.player_y[15:0])
               + prod_r[31:16];
    u_raw    = frac[15 -: TEX_W];
    mirror   = (!item_r.hit_side && dx_pos) || (item_r.hit_side && dy_neg);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:     if (in_valid) state_nxt = F_DIV_LH;
      F_DIV_LH:   if (div_done) state_nxt = span_empty ? F_IDLE : F_DIV_STEP;
      F_DIV_STEP: if (div_done) state_nxt = F_POS;
      F_POS:      state_nxt = F_PUSH;
      F_PUSH:     if (!q_stat.full) state_nxt = F_IDLE;
      default:    state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state_r != F_IDLE);
    div_start    = ((state_r == F_IDLE) && in_valid)
                   || ((state_r == F_DIV_LH) && div_done && !span_empty);
    div_dividend = (state_r == F_IDLE) ? DVD_W'(SCREEN_H) << 16 : DVD_W'(TEX_SIZE) << 16;
    div_divisor  = (state_r == F_IDLE) ? in_data.wall_distance : DVS_W'(lh_sat);
    q_push       = (state_r == F_PUSH) && !q_stat.full;

    q_desc.column       = item_r.column;
    q_desc.texel_u      = mirror ? ~u_raw : u_raw;
    q_desc.start_row    = start_r;
    q_desc.stop_row     = stop_r;
    q_desc.tex_step     = step_r;
    q_desc.tex_position = pos_r;
    if (!item_r.hit_side) begin
      q_desc.face_valid = dx_pos || dx_neg;
      q_desc.face       = dx_neg ? 2'd1 : 2'd0;
    end else begin
      q_desc.face_valid = dy_pos || dy_neg;
      q_desc.face       = dy_neg ? 2'd3 : (dy_pos ? 2'd2 : 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == F_IDLE) && in_valid) begin
      item_r <= in_data;
    end
    if (state_r == F_DIV_LH) begin
      prod_r <= hit_prod[31:0];
      if (div_done) begin
        lh_r    <= lh_sat;
        start_r <= start_c;
        stop_r  <= stop_c;
      end
    end
    if ((state_r == F_DIV_STEP) && div_done) begin
      step_r <= 32'(div_quot);
    end
    if (state_r == F_POS) begin
      pos_r <= pos_prod[31:0];
    end
  end

endmodule

// ===== hw/rtl/twcs_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twcs_queue
// Short queue of span jobs between the front and the back.
// ---------------------------------------------------------------------------
module twcs_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  twcs_pkg::span_desc_t   push_desc,
  input  logic                   pop,
  output twcs_pkg::span_desc_t   pop_desc,
  output twcs_pkg::queue_stat_t  stat
);
  import twcs_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  span_desc_t       mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] rd_r;
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_desc;
    end
  end

  assign pop_desc   = mem_r[rd_r];
  assign stat.full  = (cnt_r == CNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// ===== hw/rtl/twcs_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twcs_back
// Walks one span job row by row and drives the registered output word.
// ---------------------------------------------------------------------------
module twcs_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  twcs_pkg::queue_stat_t  q_stat,
  input  twcs_pkg::span_desc_t   q_desc,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output twcs_pkg::out_item_t    out_data
);
  import twcs_pkg::*;

  logic             busy_r;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] end_r;
  logic [31:0]      pos_r;
  logic [31:0]      step_r;
  logic [9:0]       col_r;
  logic [TEX_W-1:0] u_r;
  logic [1:0]       face_r;
  logic             we_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             adv;
  logic             last;
  logic [ROW_W-1:0] row_inc;

  always_comb begin
    adv     = busy_r && (!out_valid_r || !out_stall);
    row_inc = row_r + 1'b1;
    last    = (row_inc == end_r);
    q_pop   = !busy_r && !q_stat.empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (adv && last) begin
        busy_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      row_r  <= q_desc.start_row;
      end_r  <= q_desc.stop_row;
      pos_r  <= q_desc.tex_position;
      step_r <= q_desc.tex_step;
      col_r  <= q_desc.column;
      u_r    <= q_desc.texel_u;
      face_r <= q_desc.face;
      we_r   <= q_desc.face_valid;
    end else if (adv) begin
      row_r <= row_inc;
      pos_r <= pos_r + step_r;
    end
    if (adv) begin
      out_data_r.out_column   <= col_r;
      out_data_r.row          <= row_r[5:0];
      out_data_r.texel_u      <= 6'(u_r);
      out_data_r.texel_v      <= 6'(pos_r[16 +: TEX_W]);
      out_data_r.face         <= face_r;
      out_data_r.write_enable <= we_r;
      out_data_r.last_pixel   <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
